>>> rtl/core/csrd_pkg.sv
package csrd_pkg;

   // Fixed field widths
   localparam int CHIP_W = 3;
   localparam int BIT_W  = 3;
   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
   localparam logic [BYTE_W-1:0] BIT_ONE   = 8'h01;
   localparam logic [BIT_W-1:0]  MSB_POS   = 3'd7;

   // Register index, taken from byte address bit 2
   localparam logic CSR_IDX_CHIP_COUNT = 1'b0;
   localparam logic CSR_IDX_LSB_FIRST  = 1'b1;

   typedef enum logic [3:0] {
      CMD_WRITE       = 4'd0,
      CMD_SET         = 4'd1,
      CMD_CLEAR       = 4'd2,
      CMD_TOGGLE      = 4'd3,
      CMD_READ        = 4'd4,
      CMD_CLEAR_ALL   = 4'd5,
      CMD_SET_ALL     = 4'd6,
      CMD_SHIFT_LEFT  = 4'd7,
      CMD_SHIFT_RIGHT = 4'd8,
      CMD_REFRESH     = 4'd9,
      CMD_LOAD        = 4'd10
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_LATCH = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_UPDATE,
      ST_SERIAL,
      ST_LATCH,
      ST_READ
   } state_type;

   // Shared byte update unit: one byte in, one byte out
   function automatic logic [BYTE_W-1:0] update_byte(
      input cmd_type            cmd,
      input logic [BYTE_W-1:0]  cur,
      input logic [BIT_W-1:0]   bit_idx,
      input logic [BYTE_W-1:0]  val,
      input logic               carry
   );
      logic [BYTE_W-1:0] mask;
      logic [BYTE_W-1:0] res;
      mask = BIT_ONE << bit_idx;
      unique case (cmd)
         CMD_WRITE, CMD_LOAD: res = val;
         CMD_SET:             res = cur | mask;
         CMD_CLEAR:           res = cur & ~mask;
         CMD_TOGGLE:          res = cur ^ mask;
         CMD_CLEAR_ALL:       res = BYTE_ZERO;
         CMD_SET_ALL:         res = BYTE_ONES;
         CMD_SHIFT_LEFT:      res = {cur[BYTE_W-2:0], carry};
         CMD_SHIFT_RIGHT:     res = {carry, cur[BYTE_W-1:1]};
         default:             res = cur;
      endcase
      return res;
   endfunction

endpackage

>>> rtl/core/cascaded_shift_register_driver_unit.sv
// Shadow-byte driver for a chain of cascaded serial-in parallel-out chips. Each
// request is one command; the block takes it only in idle and holds req_stall
// high until the command's last result has been produced. A write, set, clear,
// toggle or load element updates one byte; clear all and set all update every
// chip in use in turn; shifts first fetch the wrap bit and then update every
// chip in use in turn, each pass through the single byte update unit. Every
// change but a non-final load element then serializes the bytes in use,
// highest chip first, one data bit per cycle, followed by a latch strobe:
// 8*N+1 results for N chips in use. A read answers with one result bit. The
// serializer advances only while the result register is free, so back-pressure
// on rsp_stall holds it. Registers: chip_count at byte address 0 (zero or
// above MAX_CHIPS acts as one), lsb_first at byte address 4. Write them only
// while the block is idle.
module cascaded_shift_register_driver_unit #(
   parameter int MAX_CHIPS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [3:0]                  req_cmd,
   input  logic [csrd_pkg::CHIP_W-1:0] req_chip_index,
   input  logic [csrd_pkg::BIT_W-1:0]  req_bit_index,
   input  logic [csrd_pkg::BYTE_W-1:0] req_byte_value,
   input  logic                        req_wrap,
   input  logic                        req_last_element,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_kind,
   output logic                        rsp_bit_value,
   output logic                        rsp_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int IDX_W = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
   localparam logic [csrd_pkg::CHIP_W-1:0] MAX_CNT = csrd_pkg::CHIP_W'(MAX_CHIPS);

   // Configuration
   logic [csrd_pkg::CHIP_W-1:0] chip_count_ff;
   logic                        lsb_first_ff;
   logic                        csr_write;

   // Sequencer state
   csrd_pkg::state_type         state_ff, state_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        single_ff, single_in;
   logic [csrd_pkg::BIT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic                        carry_ff, carry_in;
   logic [csrd_pkg::CHIP_W-1:0] load_pos_ff, load_pos_in;

   // Captured request
   csrd_pkg::cmd_type           cmd_ff;
   logic [csrd_pkg::CHIP_W-1:0] ci_ff;
   logic [csrd_pkg::BIT_W-1:0]  bi_ff;
   logic [csrd_pkg::BYTE_W-1:0] val_ff;
   logic                        wrap_ff;
   logic                        lastel_ff;
   logic                        ok_ff;
   logic                        accept;

   // Shadow store with one read and one write port
   logic [csrd_pkg::BYTE_W-1:0] shadow_ff [MAX_CHIPS];
   logic [IDX_W-1:0]            rd_addr;
   logic [csrd_pkg::BYTE_W-1:0] rd_data;
   logic                        wr_en;
   logic [csrd_pkg::BYTE_W-1:0] upd_byte;

   // Result register
   logic                        rsp_valid_ff;
   csrd_pkg::kind_type          rsp_kind_ff;
   logic                        rsp_bit_ff;
   logic                        rsp_last_ff;
   logic                        out_free;
   logic                        emit;
   csrd_pkg::kind_type          emit_kind;
   logic                        emit_bit;
   logic                        emit_last;

   logic [csrd_pkg::CHIP_W-1:0] n_eff;
   logic [IDX_W-1:0]            n_last;
   logic                        req_ok;
   logic                        shift_left;
   logic                        shift_down;
   logic                        update_done;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_count_ff <= csrd_pkg::CHIP_W'(1);
         lsb_first_ff  <= 1'b0;
      end else if (csr_write) begin
         if (csr_paddr[2] == csrd_pkg::CSR_IDX_CHIP_COUNT) begin
            chip_count_ff <= csr_pwdata[csrd_pkg::CHIP_W-1:0];
         end else begin
            lsb_first_ff <= csr_pwdata[0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == csrd_pkg::CSR_IDX_LSB_FIRST) begin
         csr_prdata = 32'(lsb_first_ff);
      end else begin
         csr_prdata = 32'(chip_count_ff);
      end
   end

   // Chips in use: zero or above the maximum falls back to one
   assign n_eff = (chip_count_ff == '0 || chip_count_ff > MAX_CNT)
                  ? csrd_pkg::CHIP_W'(1) : chip_count_ff;
   assign n_last = IDX_W'(n_eff - csrd_pkg::CHIP_W'(1));
   assign req_ok = req_chip_index < n_eff;

   // ---------------------------------------------------------------------
   // Request capture
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != csrd_pkg::ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= csrd_pkg::cmd_type'(req_cmd);
         ci_ff     <= req_chip_index;
         bi_ff     <= req_bit_index;
         val_ff    <= req_byte_value;
         wrap_ff   <= req_wrap;
         lastel_ff <= req_last_element;
         ok_ff     <= req_ok;
      end
   end

   // ---------------------------------------------------------------------
   // Shadow store and shared byte update unit
   // ---------------------------------------------------------------------
   assign rd_data  = shadow_ff[rd_addr];
   assign upd_byte = csrd_pkg::update_byte(cmd_ff, rd_data, bi_ff, val_ff, carry_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHIPS; i++) begin
            shadow_ff[i] <= csrd_pkg::BYTE_ZERO;
         end
      end else if (wr_en) begin
         shadow_ff[idx_ff] <= upd_byte;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   assign out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign shift_left  = (cmd_ff == csrd_pkg::CMD_SHIFT_LEFT);
   assign shift_down  = (cmd_ff == csrd_pkg::CMD_SHIFT_RIGHT);
   assign update_done = single_ff | (shift_down ? (idx_ff == '0) : (idx_ff == n_last));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= csrd_pkg::ST_IDLE;
         load_pos_ff <= '0;
      end else begin
         state_ff    <= state_in;
         load_pos_ff <= load_pos_in;
      end
      idx_ff     <= idx_in;
      single_ff  <= single_in;
      bit_cnt_ff <= bit_cnt_in;
      carry_ff   <= carry_in;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      single_in   = single_ff;
      bit_cnt_in  = bit_cnt_ff;
      carry_in    = carry_ff;
      load_pos_in = load_pos_ff;
      rd_addr     = '0;
      wr_en       = 1'b0;
      emit        = 1'b0;
      emit_kind   = csrd_pkg::KIND_DATA;
      emit_bit    = 1'b0;
      emit_last   = 1'b0;

      unique case (state_ff)
         csrd_pkg::ST_IDLE: begin
            if (accept) begin
               // Any command but load element restarts the load position
               if (req_cmd != csrd_pkg::CMD_LOAD) begin
                  load_pos_in = '0;
               end
               unique case (csrd_pkg::cmd_type'(req_cmd))
                  csrd_pkg::CMD_WRITE, csrd_pkg::CMD_SET,
                  csrd_pkg::CMD_CLEAR, csrd_pkg::CMD_TOGGLE: begin
                     if (req_ok) begin
                        idx_in    = req_chip_index[IDX_W-1:0];
                        single_in = 1'b1;
                        state_in  = csrd_pkg::ST_UPDATE;
                     end
                  end
                  csrd_pkg::CMD_READ: begin
                     state_in = csrd_pkg::ST_READ;
                  end
                  csrd_pkg::CMD_CLEAR_ALL, csrd_pkg::CMD_SET_ALL: begin
                     idx_in    = '0;
                     single_in = 1'b0;
                     state_in  = csrd_pkg::ST_UPDATE;
                  end
                  csrd_pkg::CMD_SHIFT_LEFT, csrd_pkg::CMD_SHIFT_RIGHT: begin
                     state_in = csrd_pkg::ST_PREP;
                  end
                  csrd_pkg::CMD_REFRESH: begin
                     idx_in     = n_last;
                     bit_cnt_in = '0;
                     state_in   = csrd_pkg::ST_SERIAL;
                  end
                  csrd_pkg::CMD_LOAD: begin
                     if (load_pos_ff < n_eff) begin
                        idx_in    = load_pos_ff[IDX_W-1:0];
                        single_in = 1'b1;
                        state_in  = csrd_pkg::ST_UPDATE;
                     end else if (req_last_element) begin
                        idx_in     = n_last;
                        bit_cnt_in = '0;
                        state_in   = csrd_pkg::ST_SERIAL;
                     end
                     // Advance and saturate, or rewind on the final element
                     if (req_last_element) begin
                        load_pos_in = '0;
                     end else if (load_pos_ff < MAX_CNT) begin
                        load_pos_in = load_pos_ff + csrd_pkg::CHIP_W'(1);
                     end
                  end
                  default: begin
                     state_in = csrd_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         csrd_pkg::ST_PREP: begin
            // Fetch the bit that wraps around the far end of the chain
            rd_addr   = shift_left ? n_last : '0;
            carry_in  = wrap_ff & (shift_left ? rd_data[csrd_pkg::BYTE_W-1] : rd_data[0]);
            idx_in    = shift_left ? '0 : n_last;
            single_in = 1'b0;
            state_in  = csrd_pkg::ST_UPDATE;
         end

         csrd_pkg::ST_UPDATE: begin
            rd_addr  = idx_ff;
            wr_en    = 1'b1;
            carry_in = shift_left ? rd_data[csrd_pkg::BYTE_W-1] : rd_data[0];
            if (update_done) begin
               if (cmd_ff == csrd_pkg::CMD_LOAD && !lastel_ff) begin
                  state_in = csrd_pkg::ST_IDLE;
               end else begin
                  idx_in     = n_last;
                  bit_cnt_in = '0;
                  state_in   = csrd_pkg::ST_SERIAL;
               end
            end else begin
               idx_in = shift_down ? idx_ff - IDX_W'(1) : idx_ff + IDX_W'(1);
            end
         end

         csrd_pkg::ST_SERIAL: begin
            rd_addr = idx_ff;
            if (out_free) begin
               emit       = 1'b1;
               emit_kind  = csrd_pkg::KIND_DATA;
               emit_bit   = lsb_first_ff ? rd_data[bit_cnt_ff]
                                         : rd_data[csrd_pkg::MSB_POS - bit_cnt_ff];
               bit_cnt_in = bit_cnt_ff + csrd_pkg::BIT_W'(1);
               if (bit_cnt_ff == csrd_pkg::MSB_POS) begin
                  if (idx_ff == '0) begin
                     state_in = csrd_pkg::ST_LATCH;
                  end else begin
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end
            end
         end

         csrd_pkg::ST_LATCH: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = csrd_pkg::KIND_LATCH;
               emit_last = 1'b1;
               state_in  = csrd_pkg::ST_IDLE;
            end
         end

         csrd_pkg::ST_READ: begin
            rd_addr = ok_ff ? ci_ff[IDX_W-1:0] : '0;
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = csrd_pkg::KIND_READ;
               emit_bit  = ok_ff & rd_data[bi_ff];
               emit_last = 1'b1;
               state_in  = csrd_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Result register: hold while stalled, drop once taken
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_bit_ff  <= emit_bit;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_bit_value = rsp_bit_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> rtl/core/csrd_checker.sv
module csrd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic       rsp_bit_value,
   input logic       rsp_last
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
                                 && $stable(rsp_bit_value) && $stable(rsp_last))
      else $error("stalled result changed");

   // While a command still owes results, no new request is taken
   a_busy_while_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request taken before command finished");

   // Only latch strobes and read answers close a command
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != csrd_pkg::KIND_DATA)))
      else $error("last flag does not match result kind");

   // The block goes busy only right after taking a request
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("stall raised without a request");

endmodule

bind cascaded_shift_register_driver_unit csrd_checker u_csrd_checker (.*);

>>> tb/sv/tb_cascaded_shift_register_driver_unit.sv
`timescale 1ns / 1ps

module tb_cascaded_shift_register_driver_unit;

   localparam int CHIPS_MAX     = 4;
   localparam int SETTLE_CYCLES = 48;     // one full four-chip shift plus margin
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      csrd_pkg::kind_type kind;
      logic               bit_value;
      logic               last;
   } serial_out_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [3:0]                    req_cmd;
   logic [csrd_pkg::CHIP_W-1:0]   req_chip_index;
   logic [csrd_pkg::BIT_W-1:0]    req_bit_index;
   logic [csrd_pkg::BYTE_W-1:0]   req_byte_value;
   logic                          req_wrap;
   logic                          req_last_element;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [1:0]                    rsp_kind;
   logic                          rsp_bit_value;
   logic                          rsp_last;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [2:0]                    csr_paddr;
   logic [31:0]                   csr_pwdata;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   // Shadow copy of the chain, its settings and the load position
   logic [csrd_pkg::BYTE_W-1:0]   chain_bytes [CHIPS_MAX];
   logic [2:0]                    cfg_chip_count;
   logic                          cfg_lsb_first;
   int unsigned                   load_slot;
   bit                            item_had_effect;

   // Serial stream the block should produce, oldest entry first
   serial_out_type                expected_stream [$];

   int                            error_count = 0;
   int                            send_idle_pct = 0;
   int                            rsp_stall_pct = 0;
   int unsigned                   cycle_count;

   cascaded_shift_register_driver_unit #(.MAX_CHIPS(CHIPS_MAX)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_chip_index   (req_chip_index),
      .req_bit_index    (req_bit_index),
      .req_byte_value   (req_byte_value),
      .req_wrap         (req_wrap),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_bit_value    (rsp_bit_value),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Chain predictor
   // ---------------------------------------------------------------------

   // Zero or anything above the chain length falls back to a single chip
   function automatic int unsigned chips_active();
      if (cfg_chip_count == 0 || cfg_chip_count > CHIPS_MAX) return 1;
      return cfg_chip_count;
   endfunction

   function automatic void push_output(csrd_pkg::kind_type kind, logic bit_value,
                                       logic last);
      serial_out_type entry;
      entry.kind      = kind;
      entry.bit_value = bit_value;
      entry.last      = last;
      expected_stream.push_back(entry);
   endfunction

   // Highest chip first; each byte in the configured bit order, then the latch
   function automatic void serialize_chain();
      int unsigned n;
      int          c;
      int          b;
      n = chips_active();
      for (c = n - 1; c >= 0; c--) begin
         for (b = 0; b < 8; b++) begin
            push_output(csrd_pkg::KIND_DATA,
                        chain_bytes[c][cfg_lsb_first ? b : 7 - b], 1'b0);
         end
      end
      push_output(csrd_pkg::KIND_LATCH, 1'b0, 1'b1);
   endfunction

   function automatic void apply_command(logic [3:0] cmd,
                                         logic [csrd_pkg::CHIP_W-1:0] ci,
                                         logic [csrd_pkg::BIT_W-1:0] bi,
                                         logic [csrd_pkg::BYTE_W-1:0] val,
                                         logic wrap, logic last_el);
      int unsigned                 n;
      bit                          in_range;
      logic [csrd_pkg::BYTE_W-1:0] mask;
      logic                        carry;
      logic                        nxt;
      int                          i;
      n = chips_active();
      in_range = ci < n;
      mask = csrd_pkg::BIT_ONE << bi;
      item_had_effect = 1'b1;
      // anything but a load element restarts the load sequence
      if (cmd != csrd_pkg::CMD_LOAD) load_slot = 0;
      case (cmd)
         csrd_pkg::CMD_WRITE, csrd_pkg::CMD_SET,
         csrd_pkg::CMD_CLEAR, csrd_pkg::CMD_TOGGLE: begin
            if (!in_range) begin
               item_had_effect = 1'b0;
            end else begin
               case (cmd)
                  csrd_pkg::CMD_WRITE: chain_bytes[ci] = val;
                  csrd_pkg::CMD_SET:   chain_bytes[ci] = chain_bytes[ci] | mask;
                  csrd_pkg::CMD_CLEAR: chain_bytes[ci] = chain_bytes[ci] & ~mask;
                  default:             chain_bytes[ci] = chain_bytes[ci] ^ mask;
               endcase
               serialize_chain();
            end
         end
         csrd_pkg::CMD_READ: begin
            push_output(csrd_pkg::KIND_READ, in_range ? chain_bytes[ci][bi] : 1'b0, 1'b1);
         end
         csrd_pkg::CMD_CLEAR_ALL: begin
            for (i = 0; i < n; i++) chain_bytes[i] = csrd_pkg::BYTE_ZERO;
            serialize_chain();
         end
         csrd_pkg::CMD_SET_ALL: begin
            for (i = 0; i < n; i++) chain_bytes[i] = csrd_pkg::BYTE_ONES;
            serialize_chain();
         end
         csrd_pkg::CMD_SHIFT_LEFT: begin
            carry = wrap ? chain_bytes[n-1][csrd_pkg::MSB_POS] : 1'b0;
            for (i = 0; i < n; i++) begin
               nxt = chain_bytes[i][csrd_pkg::MSB_POS];
               chain_bytes[i] = {chain_bytes[i][csrd_pkg::BYTE_W-2:0], carry};
               carry = nxt;
            end
            serialize_chain();
         end
         csrd_pkg::CMD_SHIFT_RIGHT: begin
            carry = wrap ? chain_bytes[0][0] : 1'b0;
            for (i = n - 1; i >= 0; i--) begin
               nxt = chain_bytes[i][0];
               chain_bytes[i] = {carry, chain_bytes[i][csrd_pkg::BYTE_W-1:1]};
               carry = nxt;
            end
            serialize_chain();
         end
         csrd_pkg::CMD_REFRESH: serialize_chain();
         csrd_pkg::CMD_LOAD: begin
            if (load_slot < n) chain_bytes[load_slot] = val;
            if (load_slot < CHIPS_MAX) load_slot++;
            if (last_el) begin
               load_slot = 0;
               serialize_chain();
            end
         end
         default: item_had_effect = 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result checking and receiver back-pressure
   // ---------------------------------------------------------------------

   task automatic report_mismatch(string msg);
      error_count++;
      $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      serial_out_type head;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_stream.size() == 0) begin
               report_mismatch($sformatf("result with none pending: kind %0d bit %0d last %0d",
                                         rsp_kind, rsp_bit_value, rsp_last));
            end else begin
               head = expected_stream.pop_front();
               if (rsp_kind !== head.kind)
                  report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, head.kind));
               if (rsp_bit_value !== head.bit_value)
                  report_mismatch($sformatf("bit_value %0d, want %0d (kind %0d)",
                                            rsp_bit_value, head.bit_value, head.kind));
               if (rsp_last !== head.last)
                  report_mismatch($sformatf("last %0d, want %0d (kind %0d)",
                                            rsp_last, head.last, head.kind));
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Bound the run; a hang anywhere ends here
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request, register and sync helpers
   // ---------------------------------------------------------------------

   // Hold valid high after acceptance so back-to-back requests never drop it;
   // it is lowered only for a random idle gap before a request, or to settle.
   task automatic send_command(logic [3:0] cmd, logic [csrd_pkg::CHIP_W-1:0] ci,
                               logic [csrd_pkg::BIT_W-1:0] bi,
                               logic [csrd_pkg::BYTE_W-1:0] val, logic wrap,
                               logic last_el);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_chip_index   <= ci;
      req_bit_index    <= bi;
      req_byte_value   <= val;
      req_wrap         <= wrap;
      req_last_element <= last_el;
      do @(posedge clock); while (req_stall !== 1'b0);
      apply_command(cmd, ci, bi, val, wrap, last_el);
   endtask

   // Drop valid, wait out every pending result, then let a silent command finish
   task automatic settle_chain();
      req_valid <= 1'b0;
      while (expected_stream.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the access edge
   task automatic csr_write(logic idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == csrd_pkg::CSR_IDX_CHIP_COUNT) cfg_chip_count = value[2:0];
      else cfg_lsb_first = value[0];
      @(posedge clock);
   endtask

   task automatic set_chain_config(logic [2:0] count, logic lsb);
      csr_write(csrd_pkg::CSR_IDX_CHIP_COUNT, {29'd0, count});
      csr_write(csrd_pkg::CSR_IDX_LSB_FIRST, {31'd0, lsb});
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   task automatic run_reset();
      int i;
      req_valid        <= 1'b0;
      req_cmd          <= csrd_pkg::CMD_REFRESH;
      req_chip_index   <= '0;
      req_bit_index    <= '0;
      req_byte_value   <= '0;
      req_wrap         <= 1'b0;
      req_last_element <= 1'b0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      reset            <= 1'b1;
      for (i = 0; i < CHIPS_MAX; i++) chain_bytes[i] = csrd_pkg::BYTE_ZERO;
      cfg_chip_count = 3'd1;
      cfg_lsb_first  = 1'b0;
      load_slot      = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
   endtask

   // Cleared store under the reset settings, and a read past the one chip
   task automatic test_reset_state();
      send_command(csrd_pkg::CMD_REFRESH, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_READ, 3'd1, 3'd0, 8'h00, 1'b0, 1'b0);
      settle_chain();
   endtask

   // Every command once, index extremes, ignored commands and load corners
   task automatic test_directed_commands();
      set_chain_config(3'd4, 1'b0);
      send_command(csrd_pkg::CMD_WRITE, 3'd3, 3'd0, 8'hFF, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_WRITE, 3'd2, 3'd7, 8'hA5, 1'b1, 1'b1);
      send_command(csrd_pkg::CMD_SET, 3'd0, 3'd7, 8'h00, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_CLEAR, 3'd3, 3'd0, 8'hFF, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_TOGGLE, 3'd1, 3'd7, 8'h00, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_READ, 3'd3, 3'd7, 8'h00, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_READ, 3'd0, 3'd7, 8'h00, 1'b0, 1'b0);
      // out-of-range indices and unused codes leave the chain untouched
      send_command(csrd_pkg::CMD_WRITE, 3'd4, 3'd0, 8'h55, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_SET, 3'd7, 3'd7, 8'hFF, 1'b1, 1'b1);
      send_command(4'd11, 3'd0, 3'd0, 8'hFF, 1'b1, 1'b1);
      send_command(4'd15, 3'd7, 3'd7, 8'hFF, 1'b1, 1'b1);
      send_command(csrd_pkg::CMD_SHIFT_LEFT, 3'd0, 3'd0, 8'h00, 1'b1, 1'b0);
      send_command(csrd_pkg::CMD_SHIFT_LEFT, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_SHIFT_RIGHT, 3'd0, 3'd0, 8'h00, 1'b1, 1'b0);
      send_command(csrd_pkg::CMD_SHIFT_RIGHT, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0);
      // load interrupted by a read restarts at chip zero
      send_command(csrd_pkg::CMD_LOAD, 3'd0, 3'd0, 8'h81, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_LOAD, 3'd0, 3'd0, 8'h7E, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_READ, 3'd1, 3'd1, 8'h00, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_LOAD, 3'd0, 3'd0, 8'h11, 1'b0, 1'b1);
      send_command(csrd_pkg::CMD_SET_ALL, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_CLEAR_ALL, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0);
      settle_chain();

      // LSB first on two chips; the third load element runs past the chain
      set_chain_config(3'd2, 1'b1);
      send_command(csrd_pkg::CMD_LOAD, 3'd0, 3'd0, 8'h01, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_LOAD, 3'd0, 3'd0, 8'hC3, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_LOAD, 3'd0, 3'd0, 8'hEE, 1'b0, 1'b1);
      settle_chain();

      // zero and an oversized count both fall back to one chip
      set_chain_config(3'd0, 1'b0);
      send_command(csrd_pkg::CMD_REFRESH, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0);
      settle_chain();
      set_chain_config(3'd7, 1'b1);
      send_command(csrd_pkg::CMD_WRITE, 3'd1, 3'd0, 8'h3C, 1'b0, 1'b0);
      send_command(csrd_pkg::CMD_REFRESH, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0);
      settle_chain();
   endtask

   // Mostly well-formed traffic with random content, some load sequences,
   // some noise and broken loads. Settle between segments and retune the chain.
   task automatic test_random_phase(int idle_pct, int stall_pct, int items);
      int          done;
      int          seg;
      int          target;
      int          pick;
      int          len;
      int          k;
      int unsigned n;
      logic [3:0]  cmd;
      logic [2:0]  ci;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      done = 0;
      for (seg = 0; seg < 2; seg++) begin
         settle_chain();
         if (seg == 0) set_chain_config(3'd4, 1'($urandom_range(1, 0)));
         else set_chain_config(3'($urandom_range(7, 0)), 1'($urandom_range(1, 0)));
         target = (seg == 0) ? items / 2 : items;
         while (done < target) begin
            n = chips_active();
            pick = $urandom_range(99);
            if (pick < 20) begin
               len = $urandom_range(n + 1, 1);
               for (k = 0; k < len; k++) begin
                  // now and then leave the sequence open for the next command
                  send_command(csrd_pkg::CMD_LOAD, 3'($urandom), 3'($urandom),
                               8'($urandom), 1'($urandom),
                               (k == len - 1) && ($urandom_range(9) != 0));
               end
               done += len;
            end else begin
               if (pick < 27) begin
                  cmd = 4'($urandom_range(15, 0));
                  ci  = 3'($urandom_range(7, 0));
               end else begin
                  cmd = 4'($urandom_range(csrd_pkg::CMD_REFRESH, csrd_pkg::CMD_WRITE));
                  ci  = ($urandom_range(99) < 85) ? 3'($urandom_range(n - 1, 0))
                                                  : 3'($urandom_range(7, 0));
               end
               send_command(cmd, ci, 3'($urandom), 8'($urandom), 1'($urandom),
                            1'($urandom));
               if (item_had_effect) done++;
            end
         end
      end
      settle_chain();
   endtask

   initial begin
      run_reset();
      test_reset_state();
      test_directed_commands();
      test_random_phase(0, 0, 46);
      test_random_phase(58, 0, 46);
      test_random_phase(0, 58, 46);
      test_random_phase(33, 33, 44);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      settle_chain();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
